>>> design/tspr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tspr_pkg
// Types, constants and the shade palette of the tile and sprite renderer.
// ----------------------------------------------------------------------------
package tspr_pkg;

  localparam int SCREEN_WIDTH_DEF  = 160;
  localparam int SCREEN_HEIGHT_DEF = 144;
  localparam int SPRITE_COUNT_DEF  = 40;

  localparam int PAT_DEPTH = 4096;
  localparam int MAP_DEPTH = 1024;
  localparam int SPR_DEPTH = 64;
  localparam int PAT_AW    = $clog2(PAT_DEPTH);
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int SPR_AW    = $clog2(SPR_DEPTH);

  // bus regions
  localparam logic [3:0] PAT_REGION = 4'h8;       // 0x8000..0x8fff
  localparam logic [5:0] MAP_REGION = 6'b100110;  // 0x9800..0x9bff
  localparam logic [7:0] OAM_REGION = 8'hfe;      // 0xfe00..0xfe9f
  localparam logic [7:0] OAM_LAST   = 8'h9f;

  // byte within a sprite entry
  localparam logic [1:0] OAM_Y    = 2'd0;
  localparam logic [1:0] OAM_X    = 2'd1;
  localparam logic [1:0] OAM_TILE = 2'd2;

  // sprite visibility limits
  localparam logic [7:0] SPR_Y_LIMIT = 8'd160;
  localparam logic [7:0] SPR_X_LIMIT = 8'd168;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAP,
    ST_TILE,
    ST_FLO,
    ST_FHI,
    ST_FSH,
    ST_SPR0,
    ST_SCAN,
    ST_OUT
  } tspr_state_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } tspr_rgb_t;

  function automatic tspr_rgb_t shade_rgb(input logic [1:0] shade);
    tspr_rgb_t c;
    case (shade)
      2'd0:    c = '{red: 8'd196, green: 8'd207, blue: 8'd161};
      2'd1:    c = '{red: 8'd139, green: 8'd149, blue: 8'd109};
      2'd2:    c = '{red: 8'd77,  green: 8'd83,  blue: 8'd60};
      default: c = '{red: 8'd31,  green: 8'd31,  blue: 8'd31};
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

>>> design/tile_sprite_pixel_renderer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tile_sprite_pixel_renderer
// Byte stores for tile patterns, tile map and sprite table, and a pixel query
// sequencer that resolves background and sprite shade to an RGB color.
// ----------------------------------------------------------------------------
// After reset the block clears its stores, one pattern address per cycle with
// map and sprite stores alongside, and holds in_ready low.
// A write is stored as it is taken. A pixel query takes the map read, two
// pattern reads and a scan of the sprite table from the last entry down, one
// entry per cycle through a single coverage compare, stopping at the first
// covering sprite, whose two pattern bytes are then read. An off-screen query
// goes straight to the output register.
// The result sits in an output register, so the next item can be taken
// while it waits.
module tile_sprite_pixel_renderer #(
  parameter int SCREEN_WIDTH  = tspr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = tspr_pkg::SCREEN_HEIGHT_DEF,
  parameter int SPRITE_COUNT  = tspr_pkg::SPRITE_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic        in_cmd,
  input  wire logic [15:0] in_bus_address,
  input  wire logic [7:0]  in_write_data,
  input  wire logic [7:0]  in_pixel_x,
  input  wire logic [7:0]  in_pixel_y,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [1:0]  out_color_index,
  output      logic        out_from_sprite,
  output      logic [7:0]  out_red,
  output      logic [7:0]  out_green,
  output      logic [7:0]  out_blue
);
  import tspr_pkg::*;

  localparam logic [8:0]        ScrW       = 9'(SCREEN_WIDTH);
  localparam logic [8:0]        ScrH       = 9'(SCREEN_HEIGHT);
  localparam logic [SPR_AW-1:0] LastSprite = SPR_AW'(SPRITE_COUNT - 1);
  localparam logic [PAT_AW-1:0] ClrLast    = PAT_AW'(PAT_DEPTH - 1);

  // stores
  logic [7:0] pat_mem [PAT_DEPTH];
  logic [7:0] map_mem [MAP_DEPTH];
  logic [7:0] spy_mem [SPR_DEPTH];
  logic [7:0] spx_mem [SPR_DEPTH];
  logic [7:0] spt_mem [SPR_DEPTH];

  logic              pat_we, map_we, spy_we, spx_we, spt_we;
  logic [PAT_AW-1:0] pat_wa, pat_ra;
  logic [MAP_AW-1:0] map_wa, map_ra;
  logic [SPR_AW-1:0] spr_wa, spr_ra;
  logic [7:0]        mem_wd;
  logic [7:0]        pat_rd, map_rd, spy_rd, spx_rd, spt_rd;

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[pat_wa] <= mem_wd;
    end
    pat_rd <= pat_mem[pat_ra];
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= mem_wd;
    end
    map_rd <= map_mem[map_ra];
  end

  always_ff @(posedge clk) begin
    if (spy_we) begin
      spy_mem[spr_wa] <= mem_wd;
    end
    if (spx_we) begin
      spx_mem[spr_wa] <= mem_wd;
    end
    if (spt_we) begin
      spt_mem[spr_wa] <= mem_wd;
    end
    spy_rd <= spy_mem[spr_ra];
    spx_rd <= spx_mem[spr_ra];
    spt_rd <= spt_mem[spr_ra];
  end

  // control and working registers
  tspr_state_t       state_r, state_nxt;
  logic [PAT_AW-1:0] clr_r, clr_nxt;
  logic [7:0]        px_r, px_nxt, py_r, py_nxt;
  logic [7:0]        tile_r, tile_nxt;
  logic [2:0]        col_r, col_nxt, row_r, row_nxt;
  logic [7:0]        lo_r, lo_nxt;
  logic [1:0]        shade_r, shade_nxt;
  logic              spr_r, spr_nxt;
  logic              off_r, off_nxt;
  logic [SPR_AW-1:0] scan_r, scan_nxt, chk_r, chk_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_ci_r, out_ci_nxt;
  logic              out_fs_r, out_fs_nxt;
  tspr_rgb_t         out_rgb_r, out_rgb_nxt;

  // sprite coverage compare
  logic       spr_hidden, spr_cover, spr_hit;
  logic [9:0] dx, dy;
  tspr_rgb_t  pal;

  assign dx = {2'b00, px_r} + 10'd8  - {2'b00, spx_rd};
  assign dy = {2'b00, py_r} + 10'd16 - {2'b00, spy_rd};
  assign spr_hidden = (spy_rd == 8'd0) || (spy_rd >= SPR_Y_LIMIT) ||
                      (spx_rd == 8'd0) || (spx_rd >= SPR_X_LIMIT);
  assign spr_cover  = (dx[9:3] == 7'd0) && (dy[9:3] == 7'd0);
  assign spr_hit    = !spr_hidden && spr_cover;
  assign pal        = shade_rgb(shade_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    tile_r    <= tile_nxt;
    col_r     <= col_nxt;
    row_r     <= row_nxt;
    lo_r      <= lo_nxt;
    shade_r   <= shade_nxt;
    spr_r     <= spr_nxt;
    off_r     <= off_nxt;
    scan_r    <= scan_nxt;
    chk_r     <= chk_nxt;
    out_ci_r  <= out_ci_nxt;
    out_fs_r  <= out_fs_nxt;
    out_rgb_r <= out_rgb_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    tile_nxt      = tile_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    lo_nxt        = lo_r;
    shade_nxt     = shade_r;
    spr_nxt       = spr_r;
    off_nxt       = off_r;
    scan_nxt      = scan_r;
    chk_nxt       = chk_r;
    out_ci_nxt    = out_ci_r;
    out_fs_nxt    = out_fs_r;
    out_rgb_nxt   = out_rgb_r;
    out_valid_nxt = out_valid_r && !out_ready;

    pat_we = 1'b0;
    map_we = 1'b0;
    spy_we = 1'b0;
    spx_we = 1'b0;
    spt_we = 1'b0;
    pat_wa = in_bus_address[PAT_AW-1:0];
    map_wa = in_bus_address[MAP_AW-1:0];
    spr_wa = in_bus_address[SPR_AW+1:2];
    mem_wd = in_write_data;
    pat_ra = {tile_r, row_r, 1'b0};
    map_ra = {py_r[7:3], px_r[7:3]};
    spr_ra = scan_r;
    in_ready = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        pat_we = 1'b1;
        map_we = 1'b1;
        spy_we = 1'b1;
        spx_we = 1'b1;
        spt_we = 1'b1;
        pat_wa = clr_r;
        map_wa = clr_r[MAP_AW-1:0];
        spr_wa = clr_r[SPR_AW-1:0];
        mem_wd = 8'd0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ClrLast) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_WRITE) begin
            if (in_bus_address[15:12] == PAT_REGION) begin
              pat_we = 1'b1;
            end else if (in_bus_address[15:10] == MAP_REGION) begin
              map_we = 1'b1;
            end else if (in_bus_address[15:8] == OAM_REGION &&
                         in_bus_address[7:0] <= OAM_LAST) begin
              // attribute byte is never read, so it is not kept
              case (in_bus_address[1:0])
                OAM_Y:    spy_we = 1'b1;
                OAM_X:    spx_we = 1'b1;
                OAM_TILE: spt_we = 1'b1;
                default:  ;
              endcase
            end
          end else begin
            px_nxt  = in_pixel_x;
            py_nxt  = in_pixel_y;
            spr_nxt = 1'b0;
            off_nxt = ({1'b0, in_pixel_x} >= ScrW) || ({1'b0, in_pixel_y} >= ScrH);
            state_nxt = off_nxt ? ST_OUT : ST_MAP;
          end
        end
      end
      ST_MAP: begin
        state_nxt = ST_TILE;
      end
      ST_TILE: begin
        tile_nxt  = map_rd;
        col_nxt   = px_r[2:0];
        row_nxt   = py_r[2:0];
        state_nxt = ST_FLO;
      end
      ST_FLO: begin
        state_nxt = ST_FHI;
      end
      ST_FHI: begin
        pat_ra    = {tile_r, row_r, 1'b1};
        lo_nxt    = pat_rd;
        state_nxt = ST_FSH;
      end
      ST_FSH: begin
        // bit 7 is the leftmost pixel
        shade_nxt = {pat_rd[~col_r], lo_r[~col_r]};
        if (spr_r) begin
          state_nxt = ST_OUT;
        end else begin
          scan_nxt  = LastSprite;
          state_nxt = ST_SPR0;
        end
      end
      ST_SPR0: begin
        chk_nxt   = scan_r;
        scan_nxt  = scan_r - 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        // read data belongs to entry chk_r, next entry already addressed
        if (spr_hit) begin
          tile_nxt  = spt_rd;
          col_nxt   = dx[2:0];
          row_nxt   = dy[2:0];
          spr_nxt   = 1'b1;
          state_nxt = ST_FLO;
        end else if (chk_r == '0) begin
          state_nxt = ST_OUT;
        end else begin
          chk_nxt  = scan_r;
          scan_nxt = scan_r - 1'b1;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (off_r) begin
            out_ci_nxt  = 2'd0;
            out_fs_nxt  = 1'b0;
            out_rgb_nxt = '0;
          end else begin
            out_ci_nxt  = shade_r;
            out_fs_nxt  = spr_r;
            out_rgb_nxt = pal;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_color_index = out_ci_r;
  assign out_from_sprite = out_fs_r;
  assign out_red         = out_rgb_r.red;
  assign out_green       = out_rgb_r.green;
  assign out_blue        = out_rgb_r.blue;

endmodule
`default_nettype wire

>>> tb/sv/tb_tile_sprite_pixel_renderer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_tile_sprite_pixel_renderer
// Self-checking bench for the tile and sprite pixel renderer. Directed writes
// and pixel queries cover the reset state, background lookup, sprite priority
// and ignored writes. Random scenes then run with random gaps, long receiver
// stalls and back-to-back traffic. Every result is checked against a shadow
// copy of the pattern, tile map and sprite stores.
// ----------------------------------------------------------------------------
module tb_tile_sprite_pixel_renderer;
  import tspr_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 64;
  localparam int HOLD_CYCLES    = 400;
  localparam int SPRITE_BYTES   = 4 * SPRITE_COUNT_DEF;

  typedef enum logic [1:0] {
    RGN_NONE,
    RGN_PATTERN,
    RGN_MAP,
    RGN_SPRITE
  } region_t;

  typedef struct packed {
    logic [1:0] shade;
    logic       sprite;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_cmd;
  logic [15:0] in_bus_address;
  logic [7:0]  in_write_data;
  logic [7:0]  in_pixel_x;
  logic [7:0]  in_pixel_y;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_color_index;
  logic        out_from_sprite;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;

  // shadow stores
  logic [7:0] pattern_mem  [PAT_DEPTH];
  logic [7:0] tile_map_mem [MAP_DEPTH];
  logic [7:0] sprite_mem   [SPRITE_BYTES];

  pixel_t expected_pixels[$];
  int     fail_count     = 0;
  int     stalled_cycles = 0;
  int     rx_hold        = 0;
  bit     tx_idle_en     = 1'b1;
  bit     rx_idle_en     = 1'b1;

  tile_sprite_pixel_renderer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_bus_address  (in_bus_address),
    .in_write_data   (in_write_data),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_color_index (out_color_index),
    .out_from_sprite (out_from_sprite),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic region_t region_of(logic [15:0] addr);
    if (addr[15:12] == PAT_REGION) return RGN_PATTERN;
    if (addr[15:10] == MAP_REGION) return RGN_MAP;
    if (addr[15:8] == OAM_REGION && addr[7:0] <= OAM_LAST) return RGN_SPRITE;
    return RGN_NONE;
  endfunction

  // bit 7 of each plane byte is the leftmost column
  function automatic logic [1:0] pattern_shade(logic [7:0] tile, logic [2:0] col,
                                               logic [2:0] row);
    logic [11:0] base;
    logic [7:0]  lo;
    logic [7:0]  hi;
    base = {tile, row, 1'b0};
    lo   = pattern_mem[base];
    hi   = pattern_mem[base | 12'd1];
    return {hi[3'd7 - col], lo[3'd7 - col]};
  endfunction

  function automatic pixel_t render_pixel(logic [7:0] px, logic [7:0] py);
    pixel_t     p;
    logic [1:0] shade;
    logic       hit;
    int         sy;
    int         sx;
    int         dx;
    int         dy;
    p   = '0;
    hit = 1'b0;
    // off-screen query gives a cleared black pixel
    if (px >= SCREEN_WIDTH_DEF || py >= SCREEN_HEIGHT_DEF) return p;
    shade = pattern_shade(tile_map_mem[{py[7:3], px[7:3]}], px[2:0], py[2:0]);
    // later entries win, so scan in table order and keep the last hit
    for (int s = 0; s < SPRITE_COUNT_DEF; s++) begin
      sy = int'(sprite_mem[4*s + OAM_Y]);
      sx = int'(sprite_mem[4*s + OAM_X]);
      if (sy == 0 || sy >= SPR_Y_LIMIT || sx == 0 || sx >= SPR_X_LIMIT) continue;
      dx = int'(px) - (sx - 8);
      dy = int'(py) - (sy - 16);
      if (dx < 0 || dx > 7 || dy < 0 || dy > 7) continue;
      shade = pattern_shade(sprite_mem[4*s + OAM_TILE], dx[2:0], dy[2:0]);
      hit   = 1'b1;
    end
    p.shade  = shade;
    p.sprite = hit;
    case (shade)
      2'd0:    {p.red, p.green, p.blue} = {8'd196, 8'd207, 8'd161};
      2'd1:    {p.red, p.green, p.blue} = {8'd139, 8'd149, 8'd109};
      2'd2:    {p.red, p.green, p.blue} = {8'd77,  8'd83,  8'd60};
      default: {p.red, p.green, p.blue} = {8'd31,  8'd31,  8'd31};
    endcase
    return p;
  endfunction

  // valid stays high after a transfer until the next gap, so a back-to-back
  // item never lowers and raises it in one step
  task automatic send_item(logic cmd, logic [15:0] addr, logic [7:0] data,
                           logic [7:0] px, logic [7:0] py);
    int gap;
    gap = tx_idle_en ? int'($urandom_range(0, 7)) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_bus_address <= addr;
    in_write_data  <= data;
    in_pixel_x     <= px;
    in_pixel_y     <= py;
    do @(posedge clk); while (!in_ready);
    if (cmd == CMD_WRITE) begin
      case (region_of(addr))
        RGN_PATTERN: pattern_mem[addr[PAT_AW-1:0]] = data;
        RGN_MAP:     tile_map_mem[addr[MAP_AW-1:0]] = data;
        RGN_SPRITE:  sprite_mem[addr[7:0]] = data;
        default:     ;
      endcase
    end else begin
      expected_pixels.push_back(render_pixel(px, py));
    end
  endtask

  task automatic query_pixel(int px, int py);
    send_item(CMD_QUERY, 16'($urandom), 8'($urandom), 8'(px), 8'(py));
  endtask

  task automatic write_byte(logic [15:0] addr, logic [7:0] data);
    send_item(CMD_WRITE, addr, data, 8'($urandom), 8'($urandom));
  endtask

  task automatic wait_pixels_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_pixels.size() != 0);
  endtask

  task automatic test_after_reset();
    query_pixel(0, 0);
    query_pixel(159, 143);
    query_pixel(160, 143);
    query_pixel(159, 144);
    query_pixel(255, 255);
  endtask

  task automatic test_background_lookup();
    // tile 1 row 0: leftmost column shade 3, next shade 2, rightmost shade 2
    write_byte(16'h8010, 8'h80);
    write_byte(16'h8011, 8'hc1);
    write_byte(16'h9800, 8'h01);
    query_pixel(0, 0);
    query_pixel(1, 0);
    query_pixel(7, 0);
  endtask

  task automatic test_sprite_priority();
    // first entry over the top-left tile, blank tile: opaque shade 0
    write_byte(16'hfe00, 8'd16);
    write_byte(16'hfe01, 8'd8);
    query_pixel(1, 0);
    // last entry on the same spot overrides it
    write_byte(16'hfe9c, 8'd16);
    write_byte(16'hfe9d, 8'd8);
    write_byte(16'hfe9e, 8'd1);
    query_pixel(7, 0);
    // hidden by y, then by x
    write_byte(16'hfe9c, 8'd160);
    query_pixel(7, 0);
    write_byte(16'hfe9c, 8'd16);
    write_byte(16'hfe9d, 8'd168);
    query_pixel(0, 0);
  endtask

  task automatic test_ignored_writes();
    write_byte(16'h97ff, 8'hff);
    write_byte(16'h9c00, 8'hff);
    write_byte(16'hfea0, 8'hff);
    write_byte(16'hffff, 8'hff);
    query_pixel(2, 0);
  endtask

  // mostly sprites clustered near the top-left so boxes overlap, queries aimed
  // at sprite boxes, plus stray writes and off-screen queries
  task automatic test_random_traffic(int count, bit tx_idle, bit rx_idle);
    int          done;
    int          pick;
    int          s;
    int          px;
    int          py;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [7:0]  idx;
    tx_idle_en = tx_idle;
    rx_idle_en = rx_idle;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      data = 8'($urandom);
      if (pick < 40) begin
        if (pick < 26) begin
          s  = $urandom_range(0, SPRITE_COUNT_DEF - 1);
          px = int'(sprite_mem[4*s + OAM_X]) - 8 + int'($urandom_range(0, 7));
          py = int'(sprite_mem[4*s + OAM_Y]) - 16 + int'($urandom_range(0, 7));
          if (px < 0 || px > 255 || py < 0 || py > 255) begin
            px = $urandom_range(0, SCREEN_WIDTH_DEF - 1);
            py = $urandom_range(0, SCREEN_HEIGHT_DEF - 1);
          end
        end else if (pick < 35) begin
          px = $urandom_range(0, SCREEN_WIDTH_DEF - 1);
          py = $urandom_range(0, SCREEN_HEIGHT_DEF - 1);
        end else begin
          px = $urandom_range(0, 255);
          py = $urandom_range(0, 255);
        end
        query_pixel(px, py);
      end else begin
        if (pick < 55) begin
          // favor the first few tiles so sprites and map pick up patterns
          addr = 16'h8000 + 16'($urandom_range(0, 1) ? $urandom_range(0, 127)
                                                      : $urandom_range(0, 4095));
        end else if (pick < 65) begin
          addr = 16'h9800 + 16'($urandom_range(0, 1)
                                ? $urandom_range(0, 17) * 32 + $urandom_range(0, 19)
                                : $urandom_range(0, 1023));
          if ($urandom_range(0, 3) != 0) data = 8'($urandom_range(0, 7));
        end else if (pick < 85) begin
          idx  = 8'($urandom_range(0, SPRITE_BYTES - 1));
          addr = 16'hfe00 + idx;
          case (idx[1:0])
            OAM_Y: begin
              case ($urandom_range(0, 9))
                0:       data = 8'd0;
                1:       data = 8'($urandom_range(160, 255));
                2:       data = 8'($urandom_range(1, 159));
                3:       data = 8'd159;
                default: data = 8'($urandom_range(16, 40));
              endcase
            end
            OAM_X: begin
              case ($urandom_range(0, 9))
                0:       data = 8'd0;
                1:       data = 8'($urandom_range(168, 255));
                2:       data = 8'($urandom_range(1, 167));
                3:       data = 8'd167;
                default: data = 8'($urandom_range(8, 40));
              endcase
            end
            OAM_TILE: if ($urandom_range(0, 3) != 0) data = 8'($urandom_range(0, 7));
            default:  ;
          endcase
        end else begin
          addr = 16'($urandom);
        end
        write_byte(addr, data);
      end
      done++;
    end
    wait_pixels_drained();
  endtask

  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    // sink stalls after the next transfer while queries keep coming
    rx_hold = HOLD_CYCLES;
    for (int i = 0; i < 16; i++) begin
      query_pixel($urandom_range(0, SCREEN_WIDTH_DEF - 1),
                  $urandom_range(0, SCREEN_HEIGHT_DEF - 1));
    end
    wait_pixels_drained();
  endtask

  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold > 0) stall = rx_hold;
      else stall = rx_idle_en ? int'($urandom_range(0, 7)) : 0;
      rx_hold = 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : check_pixels
    pixel_t got;
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{shade: out_color_index, sprite: out_from_sprite,
              red: out_red, green: out_green, blue: out_blue};
      if (expected_pixels.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("result with no query pending: shade %0d sprite %0b rgb %0d/%0d/%0d",
                   got.shade, got.sprite, got.red, got.green, got.blue);
      end else begin
        want = expected_pixels.pop_front();
        if (got.shade !== want.shade || got.sprite !== want.sprite ||
            got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue) begin
          fail_count++;
          if (fail_count <= 10)
            $display("pixel mismatch: expected %0d %0b %0d/%0d/%0d, got %0d %0b %0d/%0d/%0d",
                     want.shade, want.sprite, want.red, want.green, want.blue,
                     got.shade, got.sprite, got.red, got.green, got.blue);
        end
      end
    end
  end

  // counts cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stalled_cycles = 0;
    else stalled_cycles++;
    if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_cmd         = CMD_WRITE;
    in_bus_address = '0;
    in_write_data  = '0;
    in_pixel_x     = '0;
    in_pixel_y     = '0;
    for (int i = 0; i < PAT_DEPTH; i++) pattern_mem[i] = '0;
    for (int i = 0; i < MAP_DEPTH; i++) tile_map_mem[i] = '0;
    for (int i = 0; i < SPRITE_BYTES; i++) sprite_mem[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_background_lookup();
    test_sprite_priority();
    test_ignored_writes();
    wait_pixels_drained();
    test_random_traffic(420, 1'b1, 1'b1);
    test_backpressure();
    test_random_traffic(400, 1'b0, 1'b0);
    test_random_traffic(350, 1'b1, 1'b0);
    test_random_traffic(350, 1'b0, 1'b1);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_pixels.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
